### rtl/greedy_box_suppression_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy box suppression unit
// Immediate-consequence and next-cycle property checks, removable by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define GBS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define GBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/gbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants of the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int COORD_W  = 16;
    localparam int AREA_W   = 32;
    localparam int THR_W    = 16;
    localparam int UNION_W  = 33;
    localparam int PROD_W   = 49;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int COUNT_W  = 8;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    localparam logic REG_IOU_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] bottom_y;
    } gbs_box_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] bottom_y;
        logic                      frame_end;
    } gbs_in_t;

    typedef struct packed {
        logic               keep_box;
        logic [COUNT_W-1:0] kept_count;
        logic               list_overflow;
        logic               frame_done;
    } gbs_out_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [AREA_W-1:0] inter;
        logic              busy;
    } gbs_cmp_t;

    function automatic logic [COORD_W-1:0] extent(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [COORD_W:0] diff;
        diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        return (hi > lo) ? diff[COORD_W-1:0] : '0;
    endfunction

endpackage

### rtl/gbs_kept_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_kept_mem
// Kept-box store: corners and area per entry, one write and one registered read.
// ----------------------------------------------------------------------------
module gbs_kept_mem #(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  gbs_pkg::gbs_box_t         wr_box,
    input  logic [gbs_pkg::AREA_W-1:0] wr_area,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output gbs_pkg::gbs_box_t         rd_box,
    output logic [gbs_pkg::AREA_W-1:0] rd_area,
    output logic                      rd_valid
);
    import gbs_pkg::*;

    gbs_box_t          box_mem  [DEPTH];
    logic [AREA_W-1:0] area_mem [DEPTH];
    gbs_box_t          rd_box_reg;
    logic [AREA_W-1:0] rd_area_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_mem[wr_addr]  <= wr_box;
            area_mem[wr_addr] <= wr_area;
        end
        if (rd_en)
        begin
            rd_box_reg  <= box_mem[rd_addr];
            rd_area_reg <= area_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= rd_en;
    end

    assign rd_box   = rd_box_reg;
    assign rd_area  = rd_area_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### rtl/gbs_iou_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_iou_unit
// Shared overlap unit: intersection area and threshold test, one pair a cycle.
// ----------------------------------------------------------------------------
module gbs_iou_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  gbs_pkg::gbs_box_t           cur_box,
    input  logic [gbs_pkg::AREA_W-1:0]  cur_area,
    input  gbs_pkg::gbs_box_t           other_box,
    input  logic [gbs_pkg::AREA_W-1:0]  other_area,
    input  logic [gbs_pkg::THR_W-1:0]   threshold,
    output gbs_pkg::gbs_cmp_t           cmp
);
    import gbs_pkg::*;

    logic [4:0] vld_reg;

    logic [COORD_W-1:0] ew_reg;
    logic [COORD_W-1:0] eh_reg;
    logic [AREA_W-1:0]  oa1_reg;
    logic [AREA_W-1:0]  inter2_reg;
    logic [AREA_W-1:0]  oa2_reg;
    logic [AREA_W-1:0]  inter3_reg;
    logic [UNION_W-1:0] uni3_reg;
    logic [AREA_W-1:0]  inter4_reg;
    logic [PROD_W-1:0]  prod4_reg;
    logic [AREA_W-1:0]  inter5_reg;
    logic               hit5_reg;

    logic signed [COORD_W-1:0] ov_l;
    logic signed [COORD_W-1:0] ov_t;
    logic signed [COORD_W-1:0] ov_r;
    logic signed [COORD_W-1:0] ov_b;

    always_comb
    begin
        ov_l = (cur_box.left_x   > other_box.left_x)   ? cur_box.left_x   : other_box.left_x;
        ov_t = (cur_box.top_y    > other_box.top_y)    ? cur_box.top_y    : other_box.top_y;
        ov_r = (cur_box.right_x  < other_box.right_x)  ? cur_box.right_x  : other_box.right_x;
        ov_b = (cur_box.bottom_y < other_box.bottom_y) ? cur_box.bottom_y : other_box.bottom_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], valid};
    end

    always_ff @(posedge clk)
    begin
        ew_reg     <= extent(ov_l, ov_r);
        eh_reg     <= extent(ov_t, ov_b);
        oa1_reg    <= other_area;
        inter2_reg <= AREA_W'(ew_reg) * AREA_W'(eh_reg);
        oa2_reg    <= oa1_reg;
        uni3_reg   <= {1'b0, cur_area} + {1'b0, oa2_reg} - {1'b0, inter2_reg};
        inter3_reg <= inter2_reg;
        prod4_reg  <= PROD_W'(threshold) * PROD_W'(uni3_reg);
        inter4_reg <= inter3_reg;
        hit5_reg   <= {1'b0, inter4_reg, 16'b0} > prod4_reg;
        inter5_reg <= inter4_reg;
    end

    assign cmp.valid = vld_reg[4];
    assign cmp.hit   = hit5_reg;
    assign cmp.inter = inter5_reg;
    assign cmp.busy  = |vld_reg;

endmodule

### rtl/greedy_box_suppression_unit.sv
`timescale 1ns / 1ps
// A box is taken while the block is idle. It is first run against itself
// through the shared overlap unit to get its area, then each kept box of the
// current frame is read from the kept store and compared, one per cycle,
// followed by a drain of the overlap pipeline and the finish state, in which
// the result is registered. box_stall stays high throughout and drops in the
// same edge that registers the result, so the next box is taken only after
// the last one is done. The finish state is held while an earlier result
// still waits on result_stall. The kept list is cleared in the same edge
// that registers the result of a box marked frame_end.
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Class-agnostic greedy NMS over score-sorted boxes with an APB threshold reg.
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_unit_assert.svh"

module greedy_box_suppression_unit #(
    parameter int MAX_KEPT = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           box_valid,
    output logic                           box_stall,
    input  gbs_pkg::gbs_in_t               box,
    output logic                           result_valid,
    input  logic                           result_stall,
    output gbs_pkg::gbs_out_t              result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbs_pkg::PADDR_W-1:0]    paddr,
    input  logic [gbs_pkg::PDATA_W-1:0]    pwdata,
    output logic [gbs_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import gbs_pkg::*;

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_AREA      = 6'b000010,
        ST_AREA_WAIT = 6'b000100,
        ST_SCAN      = 6'b001000,
        ST_DRAIN     = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [THR_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               suppress_reg, suppress_next;
    logic               result_valid_reg, result_valid_next;
    gbs_out_t           result_reg;
    gbs_box_t           cur_box_reg;
    logic               cur_fe_reg;
    logic [AREA_W-1:0]  cur_area_reg;

    logic               accept;
    logic               cfg_write;
    logic               finish_fire;
    logic               full;
    logic               store;
    logic [CNT_W-1:0]   total_inc;
    logic               rd_en;
    gbs_box_t           rd_box;
    logic [AREA_W-1:0]  rd_area;
    logic               rd_valid;
    logic               unit_valid;
    gbs_box_t           unit_other;
    gbs_cmp_t           cmp;

    assign box_stall = (state_reg != ST_IDLE);
    assign accept    = box_valid && !box_stall;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IOU_THRESHOLD);
    assign prdata    = (paddr[PADDR_W-1] == REG_IOU_THRESHOLD)
                       ? PDATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_write)
            thr_reg <= pwdata[THR_W-1:0];
    end

    // kept store
    assign full        = (total_reg == CNT_W'(MAX_KEPT));
    assign finish_fire = (state_reg == ST_FINISH) && (!result_valid_reg || !result_stall);
    assign store       = finish_fire && !suppress_reg && !full;
    assign total_inc   = total_reg + CNT_W'(store);
    assign rd_en       = (state_reg == ST_SCAN);

    gbs_kept_mem #(
        .DEPTH (MAX_KEPT),
        .IDX_W (IDX_W)
    ) u_kept_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store),
        .wr_addr  (total_reg[IDX_W-1:0]),
        .wr_box   (cur_box_reg),
        .wr_area  (cur_area_reg),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg),
        .rd_box   (rd_box),
        .rd_area  (rd_area),
        .rd_valid (rd_valid)
    );

    // area pass runs the box against itself
    assign unit_valid = (state_reg == ST_AREA) || rd_valid;
    assign unit_other = (state_reg == ST_AREA) ? cur_box_reg : rd_box;

    gbs_iou_unit u_iou_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (unit_valid),
        .cur_box    (cur_box_reg),
        .cur_area   (cur_area_reg),
        .other_box  (unit_other),
        .other_area (rd_area),
        .threshold  (thr_reg),
        .cmp        (cmp)
    );

    always_comb
    begin
        state_next        = state_reg;
        total_next        = total_reg;
        idx_next          = idx_reg;
        suppress_next     = suppress_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    suppress_next = 1'b0;
                    state_next    = ST_AREA;
                end
            end
            ST_AREA:
                state_next = ST_AREA_WAIT;
            ST_AREA_WAIT:
            begin
                if (cmp.valid)
                begin
                    idx_next   = '0;
                    state_next = (total_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (CNT_W'(idx_reg) == total_reg - CNT_W'(1))
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (!cmp.busy && !rd_valid)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    result_valid_next = 1'b1;
                    total_next        = cur_fe_reg ? '0 : total_inc;
                    state_next        = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) && cmp.valid && cmp.hit)
            suppress_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            total_reg        <= '0;
            idx_reg          <= '0;
            suppress_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            idx_reg          <= idx_next;
            suppress_reg     <= suppress_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_box_reg.left_x   <= box.left_x;
            cur_box_reg.top_y    <= box.top_y;
            cur_box_reg.right_x  <= box.right_x;
            cur_box_reg.bottom_y <= box.bottom_y;
            cur_fe_reg           <= box.frame_end;
        end
        if ((state_reg == ST_AREA_WAIT) && cmp.valid)
            cur_area_reg <= cmp.inter;
        if (finish_fire)
        begin
            result_reg.keep_box      <= store;
            result_reg.kept_count    <= COUNT_W'(total_inc);
            result_reg.list_overflow <= !suppress_reg && full;
            result_reg.frame_done    <= cur_fe_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `GBS_ASSERT_IMP(a_total_bound, clk, rst_n, 1'b1, total_reg <= CNT_W'(MAX_KEPT), "kept count beyond list size")
    `GBS_ASSERT_IMP(a_keep_xor_ovf, clk, rst_n, result_valid, !(result.keep_box && result.list_overflow), "kept and overflow together")
    `GBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, box_stall, "second box taken during work")
    `GBS_ASSERT_NEXT(a_frame_clear, clk, rst_n, finish_fire && cur_fe_reg, total_reg == '0, "list not cleared at frame end")

endmodule

### tb/sv/greedy_box_suppression_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit_tb
// Self-checking bench for the greedy box suppression unit. A queue-fed driver
// sends box beats in random bursts, a monitor checks every result beat against
// a built-in suppression predictor, and the overlap threshold is swept over
// several values, the extremes among them, through the APB port.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit_tb;
    import gbs_pkg::*;

    localparam int HELD_MAX    = 128;
    localparam int SETTLE      = 160;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int STALL_MAX   = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;

    localparam logic [PADDR_W-1:0] THR_ADDR   = PADDR_W'(4 * REG_IOU_THRESHOLD);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * (REG_IOU_THRESHOLD + 1));

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               box_valid = 1'b0;
    logic               box_stall;
    gbs_in_t            box = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    gbs_out_t           result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    greedy_box_suppression_unit #(
        .MAX_KEPT(HELD_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .box_valid(box_valid),
        .box_stall(box_stall),
        .box(box),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    gbs_box_t          held_box [HELD_MAX];
    logic [63:0]       held_area [HELD_MAX];
    int                held_n = 0;
    logic [THR_W-1:0]  thr_q16 = THR_RESET;

    gbs_in_t  pending_q [$];
    gbs_out_t verdict_q [$];
    gbs_out_t want;
    gbs_in_t  anchor_box = '0;

    int mismatches = 0;
    int queued_items = 0;
    int cycle_n = 0;
    int gap_max = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int hold_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("%0t  %s: got %0d, expected %0d", $realtime, what, got, exp_v);
        mismatches++;
    endtask

    function automatic logic [63:0] span(logic signed [COORD_W-1:0] lo,
                                         logic signed [COORD_W-1:0] hi);
        return (hi > lo) ? 64'(int'(hi) - int'(lo)) : 64'd0;
    endfunction

    function automatic logic [63:0] overlap(gbs_box_t p, gbs_box_t q);
        logic signed [COORD_W-1:0] l, t, r, bt;
        l  = (p.left_x > q.left_x) ? p.left_x : q.left_x;
        t  = (p.top_y > q.top_y) ? p.top_y : q.top_y;
        r  = (p.right_x < q.right_x) ? p.right_x : q.right_x;
        bt = (p.bottom_y < q.bottom_y) ? p.bottom_y : q.bottom_y;
        return span(l, r) * span(t, bt);
    endfunction

    function automatic gbs_out_t suppress_box(gbs_in_t b);
        gbs_box_t    cur;
        logic [63:0] area, inter, uni;
        logic        survives, full;
        gbs_out_t    r;
        cur.left_x   = b.left_x;
        cur.top_y    = b.top_y;
        cur.right_x  = b.right_x;
        cur.bottom_y = b.bottom_y;
        area = span(cur.left_x, cur.right_x) * span(cur.top_y, cur.bottom_y);
        survives = 1'b1;
        full = 1'b0;
        for (int i = 0; i < held_n; i++) begin
            inter = overlap(cur, held_box[i]);
            uni   = area + held_area[i] - inter;
            if ((inter << 16) > (64'(thr_q16) * uni))
                survives = 1'b0;
        end
        if (survives) begin
            if (held_n < HELD_MAX) begin
                held_box[held_n]  = cur;
                held_area[held_n] = area;
                held_n++;
            end else begin
                survives = 1'b0;
                full = 1'b1;
            end
        end
        r.keep_box      = survives;
        r.kept_count    = COUNT_W'(held_n);
        r.list_overflow = full;
        r.frame_done    = b.frame_end;
        if (b.frame_end)
            held_n = 0;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clip16(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return COORD_W'(v);
    endfunction

    function automatic gbs_in_t make_box(int l, int t, int r, int bt, logic fe);
        gbs_in_t nb;
        nb.left_x    = clip16(l);
        nb.top_y     = clip16(t);
        nb.right_x   = clip16(r);
        nb.bottom_y  = clip16(bt);
        nb.frame_end = fe;
        return nb;
    endfunction

    function automatic gbs_in_t spread_box();
        int l, t, w, h;
        l = int'($urandom_range(64000, 0)) - 32000;
        t = int'($urandom_range(64000, 0)) - 32000;
        w = ($urandom_range(3, 0) == 0) ? int'($urandom_range(20000, 1))
                                        : int'($urandom_range(1500, 1));
        h = ($urandom_range(3, 0) == 0) ? int'($urandom_range(20000, 1))
                                        : int'($urandom_range(1500, 1));
        return make_box(l, t, l + w, t + h, 1'b0);
    endfunction

    function automatic gbs_in_t near_box(gbs_in_t a);
        int w, h, s, l, t, r, bt;
        w = int'(a.right_x) - int'(a.left_x);
        h = int'(a.bottom_y) - int'(a.top_y);
        if (w < 2)
            w = 2;
        if (h < 2)
            h = 2;
        s  = w / 3 + 1;
        l  = int'(a.left_x) + int'($urandom_range(2 * s, 0)) - s;
        r  = l + w + int'($urandom_range(2 * s, 0)) - s;
        s  = h / 3 + 1;
        t  = int'(a.top_y) + int'($urandom_range(2 * s, 0)) - s;
        bt = t + h + int'($urandom_range(2 * s, 0)) - s;
        return make_box(l, t, r, bt, 1'b0);
    endfunction

    task automatic push_box(input gbs_in_t nb);
        pending_q.insert(pending_q.size(), nb);
        queued_items++;
    endtask

    task automatic push_frame(input int len);
        gbs_in_t nb;
        int      pick;
        logic    fe;
        for (int i = 0; i < len; i++) begin
            fe = (i == len - 1);
            pick = int'($urandom_range(99, 0));
            if (pick < 10) begin
                nb.left_x    = COORD_W'($urandom());
                nb.top_y     = COORD_W'($urandom());
                nb.right_x   = COORD_W'($urandom());
                nb.bottom_y  = COORD_W'($urandom());
                nb.frame_end = fe | ($urandom_range(15, 0) == 0);
            end else if (pick < 45) begin
                nb = near_box(anchor_box);
                nb.frame_end = fe;
            end else begin
                nb = spread_box();
                anchor_box = nb;
                nb.frame_end = fe;
            end
            push_box(nb);
        end
    endtask

    // disjoint boxes on a grid, long enough to fill the list
    task automatic push_grid_frame(input int len);
        int l, t;
        for (int i = 0; i < len; i++) begin
            l = -30000 + (i % 16) * 3000;
            t = -30000 + (i / 16) * 3000;
            push_box(make_box(l, t, l + int'($urandom_range(2500, 1)),
                              t + int'($urandom_range(2500, 1)), i == len - 1));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || box_valid || verdict_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        data = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        logic [15:0]        junk;
        junk = 16'($urandom());
        apb_write(THR_ADDR, {junk, value});
        thr_q16 = value;
        apb_read(THR_ADDR, rd);
        if (rd[THR_W-1:0] !== thr_q16)
            report_mismatch("iou_threshold readback", longint'(rd[THR_W-1:0]),
                            longint'(thr_q16));
        @(negedge clk);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            box_valid <= 1'b0;
        end else begin
            if (box_valid && !box_stall)
                verdict_q.insert(verdict_q.size(), suppress_box(box));
            if (!box_valid || !box_stall) begin
                if (gap_left != 0) begin
                    box_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end else if (pending_q.size() != 0) begin
                    box       <= pending_q.pop_front();
                    box_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= int'($urandom_range(16, 1));
                        gap_left   <= (gap_max == 0) ? 0 : int'($urandom_range(gap_max, 0));
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    box_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (stall_pct == 0) begin
            result_stall <= 1'b0;
            hold_left    <= 16;
        end else if (int'($urandom_range(99, 0)) < stall_pct) begin
            result_stall <= 1'b1;
            hold_left    <= int'($urandom_range(STALL_MAX, 1));
        end else begin
            result_stall <= 1'b0;
            hold_left    <= int'($urandom_range(12, 1));
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", longint'(1), longint'(0));
            end else begin
                want = verdict_q.pop_front();
                if (result.keep_box !== want.keep_box)
                    report_mismatch("keep_box", longint'(result.keep_box),
                                    longint'(want.keep_box));
                if (result.kept_count !== want.kept_count)
                    report_mismatch("kept_count", longint'(result.kept_count),
                                    longint'(want.kept_count));
                if (result.list_overflow !== want.list_overflow)
                    report_mismatch("list_overflow", longint'(result.list_overflow),
                                    longint'(want.list_overflow));
                if (result.frame_done !== want.frame_done)
                    report_mismatch("frame_done", longint'(result.frame_done),
                                    longint'(want.frame_done));
            end
        end
    end

    always @(posedge clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("greedy_box_suppression_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0]   thr_plan [PHASES];
        int                 gap_plan [PHASES];
        int                 stall_plan [PHASES];
        int                 goal;
        logic [PDATA_W-1:0] rd;

        thr_plan   = '{16'd29491, 16'd0, 16'd65535, 16'd32768, 16'd0, 16'd1, 16'd65534, 16'd0};
        thr_plan[4] = THR_W'($urandom());
        thr_plan[7] = THR_W'($urandom());
        gap_plan   = '{0, 3, 8, 1, 0, 12, 4, 2};
        stall_plan = '{0, 25, 50, 10, 70, 0, 35, 90};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset threshold: extremes, duplicates, inverted and empty boxes
        gap_max   = 2;
        stall_pct = 30;
        push_box(make_box(-32768, -32768, 32767, 32767, 1'b0));
        push_box(make_box(-32768, -32768, 32767, 32767, 1'b0));
        push_box(make_box(100, 100, -100, -100, 1'b0));
        push_box(make_box(5, 5, 5, 5, 1'b0));
        push_box(make_box(-32768, -32768, 0, 32767, 1'b0));
        push_box(make_box(0, 0, 32767, 32767, 1'b0));
        push_box(make_box(-32768, 32767, 32767, -32768, 1'b1));
        push_box(make_box(0, 0, 160, 160, 1'b0));
        push_box(make_box(16, 0, 176, 160, 1'b0));
        push_box(make_box(80, 0, 240, 160, 1'b0));
        push_box(make_box(-32768, -32768, -32752, -32752, 1'b0));
        push_box(make_box(32751, 32751, 32767, 32767, 1'b1));
        wait_idle();

        // zero threshold: any shared area drops
        set_threshold(16'd0);
        push_box(make_box(0, 0, 160, 160, 1'b0));
        push_box(make_box(159, 159, 320, 320, 1'b0));
        push_box(make_box(160, 0, 320, 160, 1'b0));
        push_box(make_box(0, 0, 160, 160, 1'b1));
        wait_idle();

        // full threshold: only exact duplicates drop; unmapped register write ignored
        set_threshold(16'd65535);
        apb_write(SPARE_ADDR, $urandom());
        apb_read(THR_ADDR, rd);
        if (rd[THR_W-1:0] !== thr_q16)
            report_mismatch("iou_threshold after unmapped write", longint'(rd[THR_W-1:0]),
                            longint'(thr_q16));
        @(negedge clk);
        push_box(make_box(-1000, -1000, 1000, 1000, 1'b0));
        push_box(make_box(-1000, -1000, 1000, 1000, 1'b0));
        push_box(make_box(-1000, -1000, 1000, 999, 1'b0));
        push_box(make_box(0, 0, 0, 0, 1'b1));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            gap_max   = gap_plan[p];
            stall_pct = stall_plan[p];
            set_threshold(thr_plan[p]);
            goal = queued_items + PHASE_ITEMS;
            if (p == 1 || p == 5)
                push_grid_frame(int'($urandom_range(134, 129)));
            while (queued_items < goal)
                push_frame(($urandom_range(9, 0) == 0) ? int'($urandom_range(60, 25))
                                                       : int'($urandom_range(20, 1)));
            wait_idle();
        end

        if (mismatches == 0)
            $display("greedy_box_suppression_unit: match");
        else
            $display("greedy_box_suppression_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/gbs_pkg.sv
rtl/gbs_kept_mem.sv
rtl/gbs_iou_unit.sv
rtl/greedy_box_suppression_unit.sv
tb/sv/greedy_box_suppression_unit_tb.sv
